// ----- rtl/etb_pkg.sv -----
// Shared types and constants for the elimination tree builder.
// No dependencies; imported by etb_anc_ram and elimination_tree_builder_unit.
package etb_pkg;

    localparam int NODE_W = 10;
    localparam int DATA_W = 24;

    // tuser code for an input item
    localparam logic MODE_ENTRY = 1'b0;
    localparam logic MODE_START = 1'b1;

    typedef logic [NODE_W-1:0] t_node;

    // one ancestor store entry: valid flag and ancestor column
    typedef struct packed {
        logic  valid;
        t_node anc;
    } t_anc_entry;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_WALK  = 3'b100
    } t_state;

endpackage

// ----- rtl/etb_anc_ram.sv -----
// Ancestor store: one write port, one read port, read data registered.
// Depends on etb_pkg for the entry type.
module etb_anc_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  etb_pkg::t_anc_entry i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output etb_pkg::t_anc_entry o_rdata
);
    import etb_pkg::*;

    t_anc_entry r_mem [DEPTH];
    t_anc_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/elimination_tree_builder_unit.sv -----
// Elimination tree builder top level: stream ports, walk sequencer, output register.
// Depends on etb_pkg and etb_anc_ram.
//
// Takes the upper-triangle nonzeros of a symmetric matrix in column order and
// emits one (child, parent) link each time a node first gains an ancestor.
// Each entry is taken and then walks its compressed ancestor chain at one
// node per cycle, holding only at the root while a link still waits on the
// output, since every hop is a read of the ancestor memory followed by a
// write-back of the current column; an ignored entry does not walk. The next
// item is taken while a link still waits on the output. A start command, and
// reset, run a clearing pass over all MAX_NODES entries of the ancestor memory,
// one entry per cycle, during which no item is taken.
module elimination_tree_builder_unit #(
    parameter int MAX_NODES = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [9:0] row_index, [19:10] col_index, [23:20] zero
    input  logic [etb_pkg::DATA_W-1:0]  i_s_axis_tdata,
    // [0] mode
    input  logic                        i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [9:0] child_node, [19:10] parent_node, [23:20] zero
    output logic [etb_pkg::DATA_W-1:0]  o_m_axis_tdata
);
    import etb_pkg::*;

    localparam int          AW      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam logic [31:0] NODES_L = 32'(MAX_NODES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    t_node         r_node, n_node;
    t_node         r_col, n_col;
    logic          r_out_valid, n_out_valid;
    t_node         r_out_child, n_out_child;
    t_node         r_out_parent, n_out_parent;

    t_node         in_row, in_col;
    logic          accept, entry_ok;
    logic          out_busy, next_ok;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_anc_entry    mem_wdata, mem_rdata;

    assign in_row = i_s_axis_tdata[NODE_W-1:0];
    assign in_col = i_s_axis_tdata[2*NODE_W-1:NODE_W];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign entry_ok        = (in_row < in_col) && (32'(in_row) < NODES_L)
                             && (32'(in_col) < NODES_L);

    assign out_busy = r_out_valid && !i_m_axis_tready;
    // follow the stored ancestor only while it stays below the column
    assign next_ok  = mem_rdata.valid && (32'(mem_rdata.anc) < NODES_L)
                      && (mem_rdata.anc < r_col);

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_node       = r_node;
        n_col        = r_col;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_child  = r_out_child;
        n_out_parent = r_out_parent;
        mem_we       = 1'b0;
        mem_waddr    = AW'(r_node);
        mem_wdata    = '{valid: 1'b1, anc: r_col};
        mem_raddr    = AW'(r_node);

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '{valid: 1'b0, anc: '0};
                if (r_clr_addr == LAST_ADDR) begin
                    n_state    = ST_IDLE;
                    n_clr_addr = '0;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                mem_raddr = AW'(in_row);
                if (accept) begin
                    n_node = in_row;
                    n_col  = in_col;
                    if (i_s_axis_tuser == MODE_START) begin
                        n_state = ST_CLEAR;
                    end else if (entry_ok) begin
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (!mem_rdata.valid) begin
                    // root found: link it, but hold while the output is full
                    if (!out_busy) begin
                        mem_we       = 1'b1;
                        n_out_valid  = 1'b1;
                        n_out_child  = r_node;
                        n_out_parent = r_col;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    mem_we = 1'b1;
                    if (next_ok) begin
                        mem_raddr = AW'(mem_rdata.anc);
                        n_node    = mem_rdata.anc;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node       <= n_node;
        r_col        <= n_col;
        r_out_child  <= n_out_child;
        r_out_parent <= n_out_parent;
    end

    etb_anc_ram #(
        .DEPTH (MAX_NODES),
        .AW    (AW)
    ) u_anc_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(DATA_W - 2*NODE_W){1'b0}}, r_out_parent, r_out_child};

endmodule

// ----- tb/elimination_tree_builder_unit_test.sv -----
// Self-checking testbench for elimination_tree_builder_unit: stream entries and start
// commands in, compare every parent link against an in-bench elimination tree predictor.
// Depends on etb_pkg and the elimination_tree_builder_unit RTL.
module elimination_tree_builder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import etb_pkg::*;

    localparam int NODES = 1024;

    typedef struct packed {
        t_node child;
        t_node parent;
    } t_link;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic [DATA_W-1:0] s_tdata   = '0;
    logic              s_tuser   = MODE_ENTRY;
    logic              m_tready  = 1'b0;
    logic              s_tready;
    logic              m_tvalid;
    logic [DATA_W-1:0] m_tdata;

    // predictor state: ancestor column and valid flag per node
    t_node anc_col [NODES];
    bit    anc_set [NODES];
    t_link link_queue [$];

    int err_count   = 0;
    int burst_left  = 0;
    int useful_sent = 0;

    // receiver stall control
    int hold_req    = 0;
    int hold_left   = 0;
    int rx_style    = 0;
    int style_left  = 0;
    int stall_phase = 0;
    t_link want_link;

    elimination_tree_builder_unit #(
        .MAX_NODES(NODES)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Walk the ancestor chain with path compression; queue the link if one is found.
    task automatic predict_links(input logic mode, input t_node row, input t_node col);
        int unsigned node;
        int unsigned hops;
        t_node       next;
        bit          had;
        t_link       link;
        if (mode == MODE_START) begin
            for (int i = 0; i < NODES; i++) anc_set[i] = 1'b0;
            return;
        end
        if (row >= col) return;
        node = row;
        hops = 0;
        while (node < col && hops < NODES) begin
            had           = anc_set[node];
            next          = anc_col[node];
            anc_col[node] = col;
            anc_set[node] = 1'b1;
            if (!had) begin
                link.child  = t_node'(node);
                link.parent = col;
                link_queue.insert(link_queue.size(), link);
                return;
            end
            node = next;
            hops++;
        end
    endtask

    task automatic send_item(input logic mode, input t_node row, input t_node col);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(DATA_W - 2 * NODE_W){1'b0}}, col, row};
        do @(posedge clk); while (s_tready !== 1'b1);
        predict_links(mode, row, col);
        burst_left--;
        if (mode == MODE_ENTRY && row < col) useful_sent++;
    endtask

    // Drop the offered item so it is not taken twice, then wait for the output to drain.
    task automatic wait_links_done();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (link_queue.size() != 0) @(posedge clk);
    endtask

    // Check each accepted link, then pick the next ready level.
    always @(posedge clk) begin
        if (rst_n && m_tvalid === 1'b1 && m_tready) begin
            if (link_queue.size() == 0) begin
                $display("%0t: unexpected link, expected none, got child %0d parent %0d",
                         $time, m_tdata[NODE_W-1:0], m_tdata[2*NODE_W-1:NODE_W]);
                err_count++;
            end else begin
                want_link = link_queue.pop_front();
                if (m_tdata[NODE_W-1:0] !== want_link.child) begin
                    $display("%0t: child mismatch, expected %0d, got %0d",
                             $time, want_link.child, m_tdata[NODE_W-1:0]);
                    err_count++;
                end
                if (m_tdata[2*NODE_W-1:NODE_W] !== want_link.parent) begin
                    $display("%0t: parent mismatch, expected %0d, got %0d",
                             $time, want_link.parent, m_tdata[2*NODE_W-1:NODE_W]);
                    err_count++;
                end
                if (m_tdata[DATA_W-1:2*NODE_W] !== '0) begin
                    $display("%0t: padding mismatch, expected 0, got %0h",
                             $time, m_tdata[DATA_W-1:2*NODE_W]);
                    err_count++;
                end
            end
        end
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (style_left == 0) begin
            rx_style   = $urandom_range(0, 3);
            style_left = $urandom_range(20, 400);
        end else begin
            style_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_style)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 9) != 0);
                default: m_tready <= ((stall_phase % 7) < 4);
            endcase
        end
        stall_phase++;
    end

    // Extremes, ignored entries, out-of-order columns and compression cases.
    task automatic test_directed();
        send_item(MODE_START, 10'd1023, 10'd1023);
        send_item(MODE_ENTRY, 10'd0, 10'd1);
        send_item(MODE_ENTRY, 10'd1, 10'd2);
        send_item(MODE_ENTRY, 10'd0, 10'd2);
        send_item(MODE_ENTRY, 10'd2, 10'd1023);
        send_item(MODE_ENTRY, 10'd5, 10'd5);
        send_item(MODE_ENTRY, 10'd1023, 10'd0);
        send_item(MODE_ENTRY, 10'd1022, 10'd1023);
        send_item(MODE_ENTRY, 10'd0, 10'd1023);
        // column goes backwards: link still found, stored ancestors overwritten lower
        send_item(MODE_ENTRY, 10'd3, 10'd4);
        send_item(MODE_ENTRY, 10'd0, 10'd4);
        send_item(MODE_ENTRY, 10'd0, 10'd4);
        send_item(MODE_ENTRY, 10'd341, 10'd682);
        send_item(MODE_START, 10'd0, 10'd0);
        send_item(MODE_ENTRY, 10'd0, 10'd1);
        send_item(MODE_ENTRY, 10'd0, 10'd0);
        send_item(MODE_ENTRY, 10'd511, 10'd512);
        send_item(MODE_ENTRY, 10'd1, 10'd512);
        send_item(MODE_ENTRY, 10'd0, 10'd512);
        wait_links_done();
    endtask

    // Build a long chain, then walk all of it in one entry.
    task automatic test_deep_chain();
        send_item(MODE_START, 10'd0, 10'd0);
        for (int i = 0; i < 150; i++) send_item(MODE_ENTRY, t_node'(i), t_node'(i + 1));
        send_item(MODE_ENTRY, 10'd0, 10'd151);
        send_item(MODE_ENTRY, 10'd0, 10'd152);
        wait_links_done();
    endtask

    // Hold the output off long enough for the input to back up.
    task automatic test_output_stall();
        hold_req = 3000;
        while (hold_left == 0) @(posedge clk);
        send_item(MODE_START, 10'd0, 10'd0);
        for (int i = 0; i < 30; i++) send_item(MODE_ENTRY, t_node'(i), t_node'(i + 1));
        wait_links_done();
    endtask

    // Mostly well-formed matrices with random content, mixed with noise.
    task automatic test_random_matrices();
        int    n;
        int    entries;
        int    step_max;
        int    c;
        t_node row;
        t_node col;
        while (useful_sent < 620) begin
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(5, 15)) begin
                    send_item(($urandom_range(0, 15) == 0) ? MODE_START : MODE_ENTRY,
                              t_node'($urandom_range(0, 1023)),
                              t_node'($urandom_range(0, 1023)));
                end
            end else begin
                send_item(MODE_START, t_node'($urandom_range(0, 1023)),
                          t_node'($urandom_range(0, 1023)));
                n       = ($urandom_range(0, 9) == 0) ? NODES : $urandom_range(2, 48);
                entries = $urandom_range(4, 40);
                step_max = ((n - 1) * 2) / entries;
                if (step_max < 1) step_max = 1;
                c = $urandom_range(1, (n - 1 < 8) ? n - 1 : 8);
                for (int e = 0; e < entries; e++) begin
                    if ($urandom_range(0, 2) == 0) c += $urandom_range(1, step_max);
                    if (c > n - 1 || (n == NODES && e == entries - 1)) c = n - 1;
                    col = t_node'(c);
                    row = t_node'($urandom_range(0, c - 1));
                    case ($urandom_range(0, 15))
                        0: row = t_node'($urandom_range(c, 1023));
                        1: col = t_node'($urandom_range(0, c));
                        default: ;
                    endcase
                    send_item(MODE_ENTRY, row, col);
                end
                if ($urandom_range(0, 7) == 0) wait_links_done();
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_deep_chain();
        test_output_stall();
        test_random_matrices();
        wait_links_done();
        // allow for a trailing walk or clearing pass
        repeat (2200) @(posedge clk);
        if (err_count == 0 && link_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (link_queue.size() != 0)
                $display("%0t: %0d links expected but never seen", $time, link_queue.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- elimination_tree_builder_unit.f -----
rtl/etb_pkg.sv
rtl/etb_anc_ram.sv
rtl/elimination_tree_builder_unit.sv
tb/elimination_tree_builder_unit_test.sv
